[rtl/clarke_park_transform_top_macros.svh]
// ----------------------------------------------------------------------------
// Clarke/Park transform assertion macros
// Shorthand for the concurrent checks, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef CLARKE_PARK_TRANSFORM_TOP_MACROS_SVH
`define CLARKE_PARK_TRANSFORM_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// Clarke/Park transform package
// Shared types, Q1.15 constants, the quarter-wave sine table and the
// round-and-saturate helper.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_LEN     = 1 << (SINE_TABLE_BITS - 2);
  localparam int NUM_LANES       = 4;

  typedef logic signed [15:0] val_t;
  typedef logic signed [17:0] opa_t;
  typedef logic signed [33:0] prod_t;
  typedef logic signed [34:0] sum_t;
  typedef logic [SINE_TABLE_BITS-1:0] idx_t;
  typedef logic [SINE_TABLE_BITS-3:0] qidx_t;
  typedef logic [14:0] qw_t;
  typedef qw_t qw_tab_t [QUARTER_LEN];

  localparam val_t INV_SQRT3_Q15  = 16'sd18919;
  localparam val_t SQRT3_HALF_Q15 = 16'sd28378;
  localparam val_t NEG_HALF_Q15   = -16'sd16384;
  localparam logic [15:0] PEAK_Q15 = 16'd32767;
  localparam val_t SAT_MAX = 16'sd32767;
  localparam val_t SAT_MIN = -16'sd32768;

  localparam real HALF_PI = 1.5707963267948966;
  localparam real STEP    = HALF_PI / QUARTER_LEN;

  // Quarter wave of round(32767*sin), built at elaboration with a Horner
  // form of the sine series; the peak entry is handled separately.
  function automatic qw_tab_t build_qw();
    qw_tab_t tab;
    real x;
    real x2;
    real s;
    for (int k = 0; k < QUARTER_LEN; k++) begin
      x  = real'(k) * STEP;
      x2 = x * x;
      s  = x * (1.0 - x2 / 6.0 * (1.0 - x2 / 20.0 * (1.0 - x2 / 42.0 *
           (1.0 - x2 / 72.0 * (1.0 - x2 / 110.0 * (1.0 - x2 / 156.0 *
           (1.0 - x2 / 210.0 * (1.0 - x2 / 272.0))))))));
      tab[k] = 15'($rtoi(s * 32767.0 + 0.5));
    end
    return tab;
  endfunction

  localparam qw_tab_t QW = build_qw();

  function automatic val_t sine_at(input idx_t idx);
    logic [1:0]  quad;
    qidx_t       r;
    qidx_t       rn;
    logic [15:0] mag;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    r    = idx[SINE_TABLE_BITS-3:0];
    rn   = ~r + qidx_t'(1);
    if (!quad[0]) begin
      mag = {1'b0, QW[r]};
    end else if (r == '0) begin
      mag = PEAK_Q15;
    end else begin
      mag = {1'b0, QW[rn]};
    end
    return quad[1] ? val_t'(-mag) : val_t'(mag);
  endfunction

  // Add one half LSB, drop 15 fraction bits with floor, clamp to 16 bits.
  function automatic val_t rnd_sat(input sum_t v);
    sum_t t;
    t = (v + sum_t'(16384)) >>> 15;
    if (t > sum_t'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (t < sum_t'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return val_t'(t);
  endfunction

endpackage

[rtl/cpt_sincos.sv]
// ----------------------------------------------------------------------------
// Clarke/Park sine and cosine lookup
// Maps the top angle bits onto the quarter-wave table for sine and cosine.
// ----------------------------------------------------------------------------
module cpt_sincos (
  input  logic [15:0]   angle_i,
  output cpt_pkg::val_t sin_o,
  output cpt_pkg::val_t cos_o
);
  import cpt_pkg::*;

  idx_t idx_s;
  idx_t idx_c;

  assign idx_s = angle_i[15 -: SINE_TABLE_BITS];
  // Cosine is the sine a quarter turn ahead; the index wraps naturally.
  assign idx_c = idx_s + idx_t'(QUARTER_LEN);

  assign sin_o = sine_at(idx_s);
  assign cos_o = sine_at(idx_c);

endmodule

[rtl/cpt_mult4.sv]
// ----------------------------------------------------------------------------
// Clarke/Park four-lane multiplier stage
// Four signed 18x16 products, registered when the stage advances.
// ----------------------------------------------------------------------------
module cpt_mult4 (
  input  logic           clk_i,
  input  logic           en_i,
  input  cpt_pkg::opa_t  op_a_i [cpt_pkg::NUM_LANES],
  input  cpt_pkg::val_t  op_b_i [cpt_pkg::NUM_LANES],
  output cpt_pkg::prod_t prod_o [cpt_pkg::NUM_LANES]
);
  import cpt_pkg::*;

  prod_t prod_q [NUM_LANES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        prod_q[i] <= op_a_i[i] * op_b_i[i];
      end
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/clarke_park_transform_top.sv]
// ----------------------------------------------------------------------------
// Clarke/Park transform top level
// Forward Clarke plus Park rotation, or inverse Park plus inverse Clarke,
// in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   mode, first/second value, angle
// out      source     out_valid_o / out_stall_i alpha, beta, d, q, phase b, c
//
// One transaction per cycle is sustained while the output is not stalled; each
// result passes through lookup, product, round, product and round stages.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the output is stalled.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module clarke_park_transform_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          mode_i,
  input  cpt_pkg::val_t first_value_i,
  input  cpt_pkg::val_t second_value_i,
  input  logic [15:0]   angle_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cpt_pkg::val_t alpha_o,
  output cpt_pkg::val_t beta_o,
  output cpt_pkg::val_t d_axis_o,
  output cpt_pkg::val_t q_axis_o,
  output cpt_pkg::val_t phase_b_o,
  output cpt_pkg::val_t phase_c_o
);
  import cpt_pkg::*;

  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic mode1_q, mode2_q, mode3_q, mode4_q;
  val_t first1_q, first2_q, first3_q, first4_q;
  val_t second1_q, second2_q, second3_q, second4_q;
  val_t sin1_q, sin2_q, sin3_q;
  val_t cos1_q, cos2_q, cos3_q;
  val_t alpha3_q, beta3_q, alpha4_q, beta4_q;
  val_t alpha3_d, beta3_d;
  val_t sin_w, cos_w;

  opa_t  opa2 [NUM_LANES];
  val_t  opb2 [NUM_LANES];
  opa_t  opa4 [NUM_LANES];
  val_t  opb4 [NUM_LANES];
  prod_t prod2 [NUM_LANES];
  prod_t prod4 [NUM_LANES];
  sum_t  sum3_a, sum3_b, sum5_a, sum5_b;
  val_t  res5_a, res5_b;
  opa_t  fwd_sum;

  val_t alpha_q, beta_q, d_axis_q, q_axis_q, phase_b_q, phase_c_q;

  // Stage enables: a stage loads when it holds nothing or its successor moves.
  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: capture the transaction and look up sine and cosine.
  cpt_sincos u_sincos (
    .angle_i (angle_i),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mode1_q   <= mode_i;
      first1_q  <= first_value_i;
      second1_q <= second_value_i;
      sin1_q    <= sin_w;
      cos1_q    <= cos_w;
    end
  end

  // Stage 2: first products. Forward mode only needs (a + 2b) / sqrt(3).
  assign fwd_sum = opa_t'(first1_q) + (opa_t'(second1_q) <<< 1);

  always_comb begin
    if (mode1_q) begin
      opa2[0] = opa_t'(first1_q);  opb2[0] = cos1_q;
      opa2[1] = opa_t'(second1_q); opb2[1] = sin1_q;
      opa2[2] = opa_t'(first1_q);  opb2[2] = sin1_q;
      opa2[3] = opa_t'(second1_q); opb2[3] = cos1_q;
    end else begin
      opa2[0] = '0;      opb2[0] = '0;
      opa2[1] = '0;      opb2[1] = '0;
      opa2[2] = fwd_sum; opb2[2] = INV_SQRT3_Q15;
      opa2[3] = '0;      opb2[3] = '0;
    end
  end

  cpt_mult4 u_mult_first (
    .clk_i  (clk_i),
    .en_i   (en2),
    .op_a_i (opa2),
    .op_b_i (opb2),
    .prod_o (prod2)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mode2_q   <= mode1_q;
      first2_q  <= first1_q;
      second2_q <= second1_q;
      sin2_q    <= sin1_q;
      cos2_q    <= cos1_q;
    end
  end

  // Stage 3: round and saturate beta, and alpha in inverse mode; forward alpha passes through.
  assign sum3_a = sum_t'(prod2[0]) - sum_t'(prod2[1]);
  assign sum3_b = sum_t'(prod2[2]) + sum_t'(prod2[3]);
  assign alpha3_d = mode2_q ? rnd_sat(sum3_a) : first2_q;
  assign beta3_d  = rnd_sat(sum3_b);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      mode3_q   <= mode2_q;
      first3_q  <= first2_q;
      second3_q <= second2_q;
      sin3_q    <= sin2_q;
      cos3_q    <= cos2_q;
      alpha3_q  <= alpha3_d;
      beta3_q   <= beta3_d;
    end
  end

  // Stage 4: Park rotation products, or inverse Clarke weights.
  always_comb begin
    if (mode3_q) begin
      opa4[0] = opa_t'(alpha3_q); opb4[0] = NEG_HALF_Q15;
      opa4[1] = opa_t'(beta3_q);  opb4[1] = SQRT3_HALF_Q15;
      opa4[2] = opa_t'(alpha3_q); opb4[2] = NEG_HALF_Q15;
      opa4[3] = opa_t'(beta3_q);  opb4[3] = SQRT3_HALF_Q15;
    end else begin
      opa4[0] = opa_t'(alpha3_q); opb4[0] = cos3_q;
      opa4[1] = opa_t'(beta3_q);  opb4[1] = sin3_q;
      opa4[2] = opa_t'(beta3_q);  opb4[2] = cos3_q;
      opa4[3] = opa_t'(alpha3_q); opb4[3] = sin3_q;
    end
  end

  cpt_mult4 u_mult_second (
    .clk_i  (clk_i),
    .en_i   (en4),
    .op_a_i (opa4),
    .op_b_i (opb4),
    .prod_o (prod4)
  );

  always_ff @(posedge clk_i) begin
    if (en4) begin
      mode4_q   <= mode3_q;
      first4_q  <= first3_q;
      second4_q <= second3_q;
      alpha4_q  <= alpha3_q;
      beta4_q   <= beta3_q;
    end
  end

  // Stage 5: round the second sums into the output register.
  assign sum5_a = sum_t'(prod4[0]) + sum_t'(prod4[1]);
  assign sum5_b = sum_t'(prod4[2]) - sum_t'(prod4[3]);
  assign res5_a = rnd_sat(sum5_a);
  assign res5_b = rnd_sat(sum5_b);

  always_ff @(posedge clk_i) begin
    if (en5) begin
      alpha_q   <= alpha4_q;
      beta_q    <= beta4_q;
      d_axis_q  <= mode4_q ? first4_q  : res5_a;
      q_axis_q  <= mode4_q ? second4_q : res5_b;
      phase_b_q <= mode4_q ? res5_a : '0;
      phase_c_q <= mode4_q ? res5_b : '0;
    end
  end

  assign out_valid_o = v5_q;
  assign alpha_o     = alpha_q;
  assign beta_o      = beta_q;
  assign d_axis_o    = d_axis_q;
  assign q_axis_o    = q_axis_q;
  assign phase_b_o   = phase_b_q;
  assign phase_c_o   = phase_c_q;

endmodule

[rtl/cpt_checker.sv]
// ----------------------------------------------------------------------------
// Clarke/Park transform port checker
// Watches the top-level ports for handshake rules, latency and pass-through.
// ----------------------------------------------------------------------------
`include "clarke_park_transform_top_macros.svh"

module cpt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          mode_i,
  input cpt_pkg::val_t first_value_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input cpt_pkg::val_t alpha_o,
  input cpt_pkg::val_t beta_o,
  input cpt_pkg::val_t d_axis_o,
  input cpt_pkg::val_t q_axis_o,
  input cpt_pkg::val_t phase_b_o,
  input cpt_pkg::val_t phase_c_o
);
  import cpt_pkg::*;

  logic [4:0] acc_q;
  logic [4:0] mode_q;
  logic [4:0] flow_q;
  val_t       first_q [5];
  logic       fresh;
  logic       out_busy;

  // A transaction accepted with the output never stalled since, now due at the output.
  assign fresh     = acc_q[4] && (&flow_q[3:0]);
  assign out_busy  = out_valid_o && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      mode_q <= '0;
      flow_q <= '0;
    end else begin
      acc_q  <= {acc_q[3:0], in_valid_i && !in_stall_o};
      mode_q <= {mode_q[3:0], mode_i};
      flow_q <= {flow_q[3:0], !out_stall_i};
    end
  end

  always_ff @(posedge clk_i) begin
    first_q[0] <= first_value_i;
    for (int i = 1; i < 5; i++) begin
      first_q[i] <= first_q[i-1];
    end
  end

  `CPT_ASSERT_NEXT(a_out_hold, out_busy, out_valid_o && $stable(alpha_o) && $stable(beta_o) && $stable(d_axis_o) && $stable(q_axis_o) && $stable(phase_b_o) && $stable(phase_c_o), "stalled result changed or vanished")
  `CPT_ASSERT_SAME(a_empty_ready, !out_valid_o, !in_stall_o, "input stalled with an empty pipeline")
  `CPT_ASSERT_SAME(a_inv_echo, fresh && mode_q[4], out_valid_o && d_axis_o == first_q[4], "inverse result late or d not echoed")
  `CPT_ASSERT_SAME(a_fwd_phase, fresh && !mode_q[4], out_valid_o && alpha_o == first_q[4] && phase_b_o == '0 && phase_c_o == '0, "forward result late or phases not zero")

endmodule

bind clarke_park_transform_top cpt_checker u_cpt_checker (.*);

[tb/tb_clarke_park_transform_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clarke/Park transform testbench
// Drives forward and inverse transforms through the valid/stall input channel
// with random gaps and output stalls. A local fixed-point model predicts every
// result frame, and each output transaction is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_clarke_park_transform_top;

  import cpt_pkg::val_t;

  localparam int  TABLE_BITS   = cpt_pkg::SINE_TABLE_BITS;
  localparam int  QUARTER      = cpt_pkg::QUARTER_LEN;
  localparam real QUARTER_TURN = 1.5707963267948966;
  localparam longint ONE_OVER_ROOT3 = 18919;
  localparam longint ROOT3_OVER_2   = 28378;
  localparam longint ONE_HALF       = 16384;
  localparam int  RANDOM_ITEMS = 1700;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  IDLE_LIMIT   = 5000;
  localparam int  SETTLE       = 20;

  localparam logic MODE_FORWARD = 1'b0;
  localparam logic MODE_INVERSE = 1'b1;

  typedef enum int {PACE_BURST, PACE_SPARSE, PACE_SLOW} pace_e;

  typedef struct packed {
    logic        mode;
    val_t        first_value;
    val_t        second_value;
    logic [15:0] angle;
    logic        drain_first;
  } phase_in_t;

  typedef struct packed {
    val_t alpha;
    val_t beta;
    val_t d_axis;
    val_t q_axis;
    val_t phase_b;
    val_t phase_c;
  } frame_out_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        mode_i         = 1'b0;
  val_t        first_value_i  = '0;
  val_t        second_value_i = '0;
  logic [15:0] angle_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  val_t        alpha_o;
  val_t        beta_o;
  val_t        d_axis_o;
  val_t        q_axis_o;
  val_t        phase_b_o;
  val_t        phase_c_o;

  phase_in_t  pending_inputs[$];
  frame_out_t expected_frames[$];
  phase_in_t  on_bus;
  int         quarter_sine [0:QUARTER];

  int    n_accepted  = 0;
  int    fail_count  = 0;
  int    hold_left   = 0;
  bit    hold_done   = 1'b0;
  int    idle_cycles = 0;
  int    tx_gap      = 0;
  int    tx_count    = 0;
  pace_e tx_pace     = PACE_BURST;
  int    rx_wait     = 0;
  int    rx_count    = 0;
  pace_e rx_pace     = PACE_BURST;

  clarke_park_transform_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .angle_i        (angle_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alpha_o        (alpha_o),
    .beta_o         (beta_o),
    .d_axis_o       (d_axis_o),
    .q_axis_o       (q_axis_o),
    .phase_b_o      (phase_b_o),
    .phase_c_o      (phase_c_o)
  );

  always #5 clk_i = ~clk_i;

  // Full-circle lookup built from the quarter wave by symmetry.
  function automatic longint sine_lookup(input int idx);
    int quad;
    int r;
    idx  = idx & ((1 << TABLE_BITS) - 1);
    quad = idx >> (TABLE_BITS - 2);
    r    = idx & (QUARTER - 1);
    case (quad)
      0:       return quarter_sine[r];
      1:       return quarter_sine[QUARTER - r];
      2:       return -quarter_sine[r];
      default: return -quarter_sine[QUARTER - r];
    endcase
  endfunction

  function automatic val_t round_sat(input longint v);
    longint t;
    t = (v + 64'sd16384) >>> 15;
    if (t > 32767) return 16'sh7fff;
    if (t < -32768) return 16'sh8000;
    return val_t'(t);
  endfunction

  function automatic frame_out_t transform_frame(input phase_in_t x);
    frame_out_t f;
    longint     s;
    longint     c;
    longint     v1;
    longint     v2;
    int         idx;
    idx = int'(x.angle >> (16 - TABLE_BITS));
    s   = sine_lookup(idx);
    c   = sine_lookup(idx + QUARTER);
    v1  = longint'(x.first_value);
    v2  = longint'(x.second_value);
    f   = '0;
    if (x.mode == MODE_FORWARD) begin
      f.alpha  = x.first_value;
      f.beta   = round_sat((v1 + 2 * v2) * ONE_OVER_ROOT3);
      f.d_axis = round_sat(v1 * c + longint'(f.beta) * s);
      f.q_axis = round_sat(longint'(f.beta) * c - v1 * s);
    end else begin
      f.d_axis  = x.first_value;
      f.q_axis  = x.second_value;
      f.alpha   = round_sat(v1 * c - v2 * s);
      f.beta    = round_sat(v1 * s + v2 * c);
      // Inverse Clarke works from the already saturated alpha and beta.
      f.phase_b = round_sat(-ONE_HALF * longint'(f.alpha) + ROOT3_OVER_2 * longint'(f.beta));
      f.phase_c = round_sat(-ONE_HALF * longint'(f.alpha) - ROOT3_OVER_2 * longint'(f.beta));
    end
    return f;
  endfunction

  function automatic int draw_wait(input pace_e pace);
    case (pace)
      PACE_BURST:  return 0;
      PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      default:     return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic val_t random_q15();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return val_t'($urandom_range(0, 6) - 3);
      3: return 16'sh8001;
      4: return val_t'(int'($urandom_range(0, 511)) - 256);
      default: return val_t'($urandom());
    endcase
  endfunction

  task automatic add_item(input logic m, input int a, input int b, input int ang,
                          input logic drain);
    phase_in_t x;
    x.mode         = m;
    x.first_value  = val_t'(a);
    x.second_value = val_t'(b);
    x.angle        = 16'(ang);
    x.drain_first  = drain;
    pending_inputs.push_back(x);
  endtask

  task automatic check_field(input string name, input val_t want, input val_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Input side: one transaction per item, random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        expected_frames.push_back(transform_frame(on_bus));
        n_accepted <= n_accepted + 1;
        tx_gap = draw_wait(tx_pace);
        tx_count++;
        if (tx_count % 64 == 0) tx_pace = pace_e'($urandom_range(0, 2));
      end
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_inputs.size() != 0 &&
                   !(pending_inputs[0].drain_first && expected_frames.size() != 0)) begin
        on_bus = pending_inputs.pop_front();
        in_valid_i     <= 1'b1;
        mode_i         <= on_bus.mode;
        first_value_i  <= on_bus.first_value;
        second_value_i <= on_bus.second_value;
        angle_i        <= on_bus.angle;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // One long output hold-off while the input side keeps offering items.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= 600) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output side: check each result transaction, then draw a stall.
  always @(posedge clk_i or negedge rst_ni) begin
    frame_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          $error("result transaction with no input pending");
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("alpha", want.alpha, alpha_o);
          check_field("beta", want.beta, beta_o);
          check_field("d_axis", want.d_axis, d_axis_o);
          check_field("q_axis", want.q_axis, q_axis_o);
          check_field("phase_b", want.phase_b, phase_b_o);
          check_field("phase_c", want.phase_c, phase_c_o);
        end
        rx_wait = draw_wait(rx_pace);
        rx_count++;
        if (rx_count % 64 == 0) rx_pace = pace_e'($urandom_range(0, 2));
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= (rx_wait > 0) || (hold_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("clarke_park_transform_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_sine[k] = $rtoi(32767.0 * $sin(QUARTER_TURN * k / QUARTER) + 0.5);
    end

    // Forward transform: zero, full-scale corners, all four quadrants.
    add_item(MODE_FORWARD, 0, 0, 0, 1'b1);
    add_item(MODE_FORWARD, 32767, 32767, 0, 1'b0);
    add_item(MODE_FORWARD, -32768, -32768, 16384, 1'b0);
    add_item(MODE_FORWARD, 32767, -32768, 32768, 1'b0);
    add_item(MODE_FORWARD, -32768, 32767, 49152, 1'b0);
    add_item(MODE_FORWARD, 32767, 32767, 8192, 1'b0);
    add_item(MODE_FORWARD, -32768, -32768, 40960, 1'b0);
    add_item(MODE_FORWARD, 1, -1, 65535, 1'b0);
    // Angle bits below the table resolution must not change the result.
    add_item(MODE_FORWARD, 12345, -6789, 16'h1200, 1'b0);
    add_item(MODE_FORWARD, 12345, -6789, 16'h123f, 1'b0);
    // Inverse transform: rotations that drive alpha, beta and phases to saturation.
    add_item(MODE_INVERSE, 0, 0, 0, 1'b0);
    add_item(MODE_INVERSE, 32767, 32767, 8192, 1'b0);
    add_item(MODE_INVERSE, -32768, -32768, 8192, 1'b0);
    add_item(MODE_INVERSE, 32767, -32768, 57344, 1'b0);
    add_item(MODE_INVERSE, -32768, 32767, 0, 1'b0);
    add_item(MODE_INVERSE, 32767, -32768, 0, 1'b0);
    add_item(MODE_INVERSE, -32768, -32768, 32768, 1'b0);
    add_item(MODE_INVERSE, 32767, 32767, 65535, 1'b0);
    add_item(MODE_INVERSE, 20000, -15000, 16'h5555, 1'b0);
    add_item(MODE_INVERSE, 20000, -15000, 16'h553f, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_item(logic'($urandom_range(0, 1)), int'(random_q15()), int'(random_q15()),
               int'($urandom_range(0, 65535)), logic'(i % 600 == 0));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_inputs.size() != 0 || in_valid_i || expected_frames.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);

    if (fail_count == 0 && expected_frames.size() == 0) begin
      $display("clarke_park_transform_top regression: pass");
    end else begin
      $display("clarke_park_transform_top regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/cpt_pkg.sv
rtl/cpt_sincos.sv
rtl/cpt_mult4.sv
rtl/clarke_park_transform_top.sv
rtl/cpt_checker.sv
tb/tb_clarke_park_transform_top.sv
